@@ design/swtx_pkg.sv @@
`timescale 1ns / 1ps
package swtx_pkg;

	typedef enum logic [1:0] {
		OP_SEND = 2'd0,
		OP_ACK  = 2'd1,
		OP_TICK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_QUEUED   = 3'd0,
		K_SENT     = 3'd1,
		K_SENT_Q   = 3'd2,
		K_RESEND   = 3'd3,
		K_ACK      = 3'd4,
		K_PASS     = 3'd5,
		K_IDLE     = 3'd6,
		K_DROP     = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OUT,
		ST_CHK,
		ST_AVAL,
		ST_ASCAN,
		ST_DCHK,
		ST_DUSE,
		ST_TICK,
		ST_TEND,
		ST_NOP,
		ST_EMIT
	} state_t;

	localparam logic [1:0] CFG_HIGH_MARK = 2'd0;
	localparam logic [1:0] CFG_LOW_MARK  = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

	localparam int          CFG_DATA_W   = 16;
	localparam logic [7:0]  ACK_MARKER   = 8'hFF;
	localparam logic [9:0]  HIGH_MARK_RST = 10'd500;
	localparam logic [9:0]  LOW_MARK_RST  = 10'd100;
	localparam logic [15:0] TIMEOUT_RST   = 16'd1000;
	localparam int          MAX_RES      = 4;

	typedef struct packed {
		op_t         operation;
		logic [15:0] packet_handle;
		logic [7:0]  ack_seq;
		logic [7:0]  ack_marker;
	} in_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] out_handle;
		logic [5:0]  seq_tag;
		logic [7:0]  window_tag;
		logic        wait_on;
		logic        wait_changed;
		logic        last;
	} out_t;

endpackage

@@ design/swtx_queue.sv @@
`timescale 1ns / 1ps
module swtx_queue #(
	parameter int DEPTH = 512,
	parameter int W     = 23
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 push_data,
	input  logic                         pop,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic                         full,
	output logic [W-1:0]                 head_data
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]  mem [DEPTH];
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [W-1:0]  rd_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) tail_q <= (tail_q == PW'(DEPTH-1)) ? '0 : tail_q + 1'b1;
			if (do_pop)  head_q <= (head_q == PW'(DEPTH-1)) ? '0 : head_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem[tail_q] <= push_data;
		rd_q <= mem[head_q];
	end

	assign count     = count_q;
	assign head_data = rd_q;
endmodule

@@ design/sliding_window_tx_controller_top.sv @@
`timescale 1ns / 1ps
// Work per item: a packet is sent or queued, an invalid ack is passed, a valid ack scans the
// in-flight list and drains queued packets, a tick walks every timer; results then leave through the output register.
// Input: one item at a time, held off by in_stall while the sequencer steps the shared
// in-flight scan, timer walk and single queue read port.
// Reset: arst_n clears all control, the tag counter restarts at 1 and the queue is empty;
// queue and in-flight entries are never cleared and are read only after being written.
module sliding_window_tx_controller_top #(
	parameter int WINDOW      = 2,
	parameter int QUEUE_DEPTH = 512,
	parameter int HANDLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  swtx_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output swtx_pkg::out_t                 out_data,
	input  logic                           cfg_wr_en,
	input  logic [1:0]                     cfg_index,
	input  logic [swtx_pkg::CFG_DATA_W-1:0] cfg_data
);
	import swtx_pkg::*;

	localparam int NT   = 2 * WINDOW;
	localparam int TW   = $clog2(NT + 1);
	localparam int TIW  = $clog2(NT);
	localparam int IXW  = $clog2(NT + 1);
	localparam int SH   = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
	localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = (QCW > 10) ? QCW : 10;
	localparam int QW   = SH + TW + 1;

	state_t state_q, state_d;
	logic [SH-1:0] hdl_q;
	logic [7:0]    aseq_q;
	logic [7:0]    amark_q;

	logic [9:0]  hi_q, lo_q;
	logic [15:0] tmo_q;

	logic [TW-1:0]  next_tag_q, next_tag_d;
	logic           round_q, round_d;
	logic [4:0]     open_q, open_d, open_inc;
	logic [NT-1:0]  outst_q, outst_d;
	logic           wait_q, wait_d, tog_q, tog_d;

	logic [SH-1:0]  fl_h_q [NT];
	logic [SH-1:0]  fl_h_d [NT];
	logic [TW-1:0]  fl_t_q [NT];
	logic [TW-1:0]  fl_t_d [NT];
	logic           fl_w_q [NT];
	logic           fl_w_d [NT];
	logic [IXW-1:0] fl_cnt_q, fl_cnt_d;

	logic [15:0]    tmr_q [NT];
	logic [15:0]    tmr_d [NT];
	logic [15:0]    tmr_load;

	kind_t          res_k_q [MAX_RES];
	kind_t          res_k_d [MAX_RES];
	logic [SH-1:0]  res_h_q [MAX_RES];
	logic [SH-1:0]  res_h_d [MAX_RES];
	logic [TW-1:0]  res_t_q [MAX_RES];
	logic [TW-1:0]  res_t_d [MAX_RES];
	logic           res_w_q [MAX_RES];
	logic           res_w_d [MAX_RES];
	logic [2:0]     nres_q, nres_d;
	logic [1:0]     k_q, k_d;

	logic [IXW-1:0] idx_q, idx_d;
	logic [1:0]     sends_q, sends_d;

	logic           out_valid_q, out_valid_d;
	out_t           out_q, out_d;

	// queue
	logic              q_push, q_pop, q_full;
	logic [QW-1:0]     q_wdata, q_rdata;
	logic [QCW-1:0]    q_count;
	logic [SH-1:0]     h_hdl;
	logic [TW-1:0]     h_tag;
	logic              h_win;
	logic              h_blocked;

	// current outgoing packet
	logic [TW-1:0]     p_tag;
	logic              p_win;

	// shared send / emit actions
	logic              snd_en;
	kind_t             snd_kind;
	logic [SH-1:0]     snd_h;
	logic [TW-1:0]     snd_t;
	logic              snd_w;
	logic              em_en;
	kind_t             em_kind;
	logic [SH-1:0]     em_h;
	logic [TW-1:0]     em_t;
	logic              em_w;

	logic              accept;
	logic              out_load;
	logic [TIW-1:0]    seq_ix;
	logic [TIW-1:0]    tix;

	swtx_queue #(.DEPTH(QUEUE_DEPTH), .W(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.count     (q_count),
		.full      (q_full),
		.head_data (q_rdata)
	);

	assign {h_hdl, h_tag, h_win} = q_rdata;
	assign h_blocked = (h_tag == TW'(1)) && (outst_q != '0);
	assign p_tag     = next_tag_q;
	assign p_win     = (next_tag_q == TW'(1)) ? ~round_q : round_q;
	assign tmr_load  = (tmo_q == '0) ? 16'd1 : tmo_q;
	assign open_inc  = (open_q < 5'd31) ? open_q + 5'd1 : open_q;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_load  = !out_valid_q || !out_stall;
	assign seq_ix    = TIW'(aseq_q - 8'd1);
	assign tix       = idx_q[TIW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q  <= HIGH_MARK_RST;
			lo_q  <= LOW_MARK_RST;
			tmo_q <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_HIGH_MARK: hi_q  <= cfg_data[9:0];
				CFG_LOW_MARK:  lo_q  <= cfg_data[9:0];
				CFG_TIMEOUT:   tmo_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_tag_q  <= TW'(1);
			round_q     <= 1'b0;
			open_q      <= '0;
			outst_q     <= '0;
			wait_q      <= 1'b0;
			tog_q       <= 1'b0;
			fl_cnt_q    <= '0;
			tmr_q       <= '{default: '0};
			nres_q      <= '0;
			k_q         <= '0;
			idx_q       <= '0;
			sends_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			next_tag_q  <= next_tag_d;
			round_q     <= round_d;
			open_q      <= open_d;
			outst_q     <= outst_d;
			wait_q      <= wait_d;
			tog_q       <= tog_d;
			fl_cnt_q    <= fl_cnt_d;
			tmr_q       <= tmr_d;
			nres_q      <= nres_d;
			k_q         <= k_d;
			idx_q       <= idx_d;
			sends_q     <= sends_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdl_q   <= in_data.packet_handle[SH-1:0];
			aseq_q  <= in_data.ack_seq;
			amark_q <= in_data.ack_marker;
		end
		fl_h_q  <= fl_h_d;
		fl_t_q  <= fl_t_d;
		fl_w_q  <= fl_w_d;
		res_k_q <= res_k_d;
		res_h_q <= res_h_d;
		res_t_q <= res_t_d;
		res_w_q <= res_w_d;
		out_q   <= out_d;
	end

	always_comb begin
		state_d     = state_q;
		next_tag_d  = next_tag_q;
		round_d     = round_q;
		open_d      = open_q;
		outst_d     = outst_q;
		wait_d      = wait_q;
		tog_d       = tog_q;
		fl_h_d      = fl_h_q;
		fl_t_d      = fl_t_q;
		fl_w_d      = fl_w_q;
		fl_cnt_d    = fl_cnt_q;
		tmr_d       = tmr_q;
		res_k_d     = res_k_q;
		res_h_d     = res_h_q;
		res_t_d     = res_t_q;
		res_w_d     = res_w_q;
		nres_d      = nres_q;
		k_d         = k_q;
		idx_d       = idx_q;
		sends_d     = sends_q;
		out_valid_d = out_valid_q && out_stall;
		out_d       = out_q;
		q_push      = 1'b0;
		q_pop       = 1'b0;
		q_wdata     = {hdl_q, p_tag, p_win};
		snd_en      = 1'b0;
		snd_kind    = K_SENT;
		snd_h       = hdl_q;
		snd_t       = p_tag;
		snd_w       = p_win;
		em_en       = 1'b0;
		em_kind     = K_IDLE;
		em_h        = '0;
		em_t        = '0;
		em_w        = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					nres_d = '0;
					tog_d  = 1'b0;
					k_d    = '0;
					idx_d  = '0;
					unique case (in_data.operation)
						OP_SEND: state_d = ST_OUT;
						OP_ACK:  state_d = ST_AVAL;
						OP_TICK: state_d = ST_TICK;
						default: state_d = ST_NOP;
					endcase
				end
			end
			ST_OUT: begin
				next_tag_d = (next_tag_q == TW'(NT)) ? TW'(1) : next_tag_q + 1'b1;
				round_d    = p_win;
				if (CMPW'(q_count) == CMPW'(hi_q) && !wait_q) begin
					wait_d = 1'b1;
					tog_d  = 1'b1;
				end else if (CMPW'(q_count) == CMPW'(lo_q) && wait_q) begin
					wait_d = 1'b0;
					tog_d  = 1'b1;
				end
				em_h = hdl_q;
				em_t = p_tag;
				em_w = p_win;
				state_d = ST_EMIT;
				if (int'(open_q) >= WINDOW || q_count != '0) begin
					q_push  = 1'b1;
					em_en   = 1'b1;
					em_kind = q_full ? K_DROP : K_QUEUED;
					if (int'(open_q) < WINDOW) state_d = ST_CHK;
				end else if (p_tag == TW'(1) && outst_q != '0) begin
					q_push  = 1'b1;
					em_en   = 1'b1;
					em_kind = K_QUEUED;
				end else begin
					snd_en   = 1'b1;
					snd_kind = K_SENT;
				end
			end
			ST_CHK: begin
				// head read was registered at the end of the previous cycle
				if (!h_blocked) begin
					q_pop    = 1'b1;
					snd_en   = 1'b1;
					snd_kind = K_SENT_Q;
					snd_h    = h_hdl;
					snd_t    = h_tag;
					snd_w    = h_win;
				end
				state_d = ST_EMIT;
			end
			ST_AVAL: begin
				if (amark_q != ACK_MARKER || aseq_q == 8'd0 || int'(aseq_q) > NT) begin
					em_en   = 1'b1;
					em_kind = K_PASS;
					state_d = ST_EMIT;
				end else begin
					tmr_d[seq_ix] = '0;
					if (open_q != '0) open_d = open_q - 5'd1;
					outst_d[seq_ix] = 1'b0;
					idx_d   = '0;
					state_d = ST_ASCAN;
				end
			end
			ST_ASCAN: begin
				em_kind = K_ACK;
				em_t    = TW'(aseq_q);
				sends_d = '0;
				if (idx_q >= fl_cnt_q) begin
					em_en   = 1'b1;
					state_d = ST_DCHK;
				end else if (8'(fl_t_q[tix]) == aseq_q) begin
					em_en = 1'b1;
					em_h  = fl_h_q[tix];
					for (int j = 0; j < NT - 1; j++) begin
						if (j >= int'(idx_q)) begin
							fl_h_d[j] = fl_h_q[j+1];
							fl_t_d[j] = fl_t_q[j+1];
							fl_w_d[j] = fl_w_q[j+1];
						end
					end
					fl_cnt_d = fl_cnt_q - 1'b1;
					state_d  = ST_DCHK;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DCHK: begin
				if (CMPW'(q_count) == CMPW'(lo_q) && wait_q) begin
					wait_d = 1'b0;
					tog_d  = 1'b1;
				end
				state_d = (q_count == '0) ? ST_EMIT : ST_DUSE;
			end
			ST_DUSE: begin
				if (h_blocked) begin
					state_d = ST_EMIT;
				end else begin
					q_pop    = 1'b1;
					snd_en   = 1'b1;
					snd_kind = K_SENT_Q;
					snd_h    = h_hdl;
					snd_t    = h_tag;
					snd_w    = h_win;
					sends_d  = sends_q + 2'd1;
					if (sends_q == 2'd2 || int'(open_inc) >= WINDOW) state_d = ST_EMIT;
					else state_d = ST_DCHK;
				end
			end
			ST_TICK: begin
				if (tmr_q[tix] > 16'd1) begin
					tmr_d[tix] = tmr_q[tix] - 16'd1;
				end else if (tmr_q[tix] == 16'd1) begin
					if (open_q == '0 || fl_cnt_q == '0) begin
						tmr_d[tix] = '0;
					end else if (int'(nres_q) < MAX_RES) begin
						// rotate the oldest in-flight packet to the back
						for (int j = 0; j < NT; j++) begin
							if (j < int'(fl_cnt_q) - 1) begin
								fl_h_d[j] = fl_h_q[(j+1) % NT];
								fl_t_d[j] = fl_t_q[(j+1) % NT];
								fl_w_d[j] = fl_w_q[(j+1) % NT];
							end else if (j == int'(fl_cnt_q) - 1) begin
								fl_h_d[j] = fl_h_q[0];
								fl_t_d[j] = fl_t_q[0];
								fl_w_d[j] = fl_w_q[0];
							end
						end
						em_en      = 1'b1;
						em_kind    = K_RESEND;
						em_h       = fl_h_q[0];
						em_t       = fl_t_q[0];
						em_w       = fl_w_q[0];
						tmr_d[tix] = tmr_load;
					end
				end
				if (idx_q == IXW'(NT - 1)) state_d = ST_TEND;
				else idx_d = idx_q + 1'b1;
			end
			ST_TEND: begin
				if (nres_q == '0) begin
					em_en   = 1'b1;
					em_kind = K_IDLE;
				end
				state_d = ST_EMIT;
			end
			ST_NOP: begin
				em_en   = 1'b1;
				em_kind = K_IDLE;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_load) begin
					out_valid_d        = 1'b1;
					out_d.kind         = res_k_q[k_q];
					out_d.out_handle   = 16'(res_h_q[k_q]);
					out_d.seq_tag      = 6'(res_t_q[k_q]);
					out_d.window_tag   = {8{res_w_q[k_q]}};
					out_d.wait_on      = wait_q;
					out_d.wait_changed = tog_q;
					out_d.last         = (3'(k_q) == nres_q - 3'd1);
					k_d = k_q + 2'd1;
					if (3'(k_q) == nres_q - 3'd1) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (snd_en) begin
			if (int'(fl_cnt_q) < NT) begin
				fl_h_d[fl_cnt_q[TIW-1:0]] = snd_h;
				fl_t_d[fl_cnt_q[TIW-1:0]] = snd_t;
				fl_w_d[fl_cnt_q[TIW-1:0]] = snd_w;
				fl_cnt_d = fl_cnt_q + 1'b1;
			end
			open_d = open_inc;
			outst_d[TIW'(snd_t - 1'b1)] = 1'b1;
			tmr_d[TIW'(snd_t - 1'b1)]   = tmr_load;
			em_en   = 1'b1;
			em_kind = snd_kind;
			em_h    = snd_h;
			em_t    = snd_t;
			em_w    = snd_w;
		end

		if (em_en && int'(nres_q) < MAX_RES) begin
			res_k_d[nres_q[1:0]] = em_kind;
			res_h_d[nres_q[1:0]] = em_h;
			res_t_d[nres_q[1:0]] = em_t;
			res_w_d[nres_q[1:0]] = em_w;
			nres_d = nres_q + 3'd1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import swtx_pkg::*;

	localparam int WIN       = 2;
	localparam int NTAGS     = 2 * WIN;
	localparam int QDEPTH    = 512;
	localparam int CYCLE_CAP = 1000000;

	typedef struct {
		int handle;
		int tag;
		int win;
	} pkt_s;

	class swtx_scoreboard;
		int hi_mark, lo_mark, tmo_ticks;
		int next_tag, round_b, open_cnt, outst, wflag;
		pkt_s fifo [QDEPTH];
		int q_head, q_cnt;
		pkt_s flight [NTAGS];
		int flight_cnt;
		int timers [NTAGS];
		int res_kind [4], res_handle [4], res_tag [4], res_win [4];
		int nres, toggled;
		out_t expected_results [$];
		int errors;

		function void reset_state();
			hi_mark = int'(HIGH_MARK_RST);
			lo_mark = int'(LOW_MARK_RST);
			tmo_ticks = int'(TIMEOUT_RST);
			next_tag = 1;
			round_b = 0;
			open_cnt = 0;
			outst = 0;
			wflag = 0;
			q_head = 0;
			q_cnt = 0;
			flight_cnt = 0;
			for (int i = 0; i < NTAGS; i++) timers[i] = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] d);
			if (idx == CFG_HIGH_MARK) hi_mark = int'(d[9:0]);
			else if (idx == CFG_LOW_MARK) lo_mark = int'(d[9:0]);
			else if (idx == CFG_TIMEOUT) tmo_ticks = int'(d);
		endfunction

		function int reload();
			return (tmo_ticks == 0) ? 1 : tmo_ticks;
		endfunction

		function void emit(int k, int h, int t, int w);
			if (nres >= MAX_RES) return;
			res_kind[nres] = k;
			res_handle[nres] = h;
			res_tag[nres] = t;
			res_win[nres] = w;
			nres++;
		endfunction

		function bit push_pkt(pkt_s p);
			if (q_cnt >= QDEPTH) return 0;
			fifo[(q_head + q_cnt) % QDEPTH] = p;
			q_cnt++;
			return 1;
		endfunction

		function void pop_pkt();
			if (q_cnt == 0) return;
			q_head = (q_head + 1) % QDEPTH;
			q_cnt--;
		endfunction

		function bit blocked(int tag);
			return tag == 1 && outst != 0;
		endfunction

		function void launch(pkt_s p, int k);
			if (flight_cnt < NTAGS) begin
				flight[flight_cnt] = p;
				flight_cnt++;
			end
			if (open_cnt < 31) open_cnt++;
			if (p.tag >= 1 && p.tag <= NTAGS) begin
				outst |= 1 << (p.tag - 1);
				timers[p.tag - 1] = reload();
			end
			emit(k, p.handle, p.tag, p.win);
		endfunction

		function void outgoing(int handle);
			pkt_s p, h;
			int qlen;
			qlen = q_cnt;
			p.handle = handle;
			p.tag = next_tag;
			next_tag = (next_tag % NTAGS) + 1;
			if (p.tag == 1) round_b ^= 8'hFF;
			p.win = round_b;
			if (qlen == hi_mark && wflag == 0) begin
				wflag = 1;
				toggled = 1;
			end else if (qlen == lo_mark && wflag == 1) begin
				wflag = 0;
				toggled = 1;
			end
			if (open_cnt >= WIN || qlen != 0) begin
				if (push_pkt(p)) emit(K_QUEUED, p.handle, p.tag, p.win);
				else emit(K_DROP, p.handle, p.tag, p.win);
				if (open_cnt < WIN) begin
					h = fifo[q_head];
					if (!blocked(h.tag)) begin
						pop_pkt();
						launch(h, K_SENT_Q);
					end
				end
			end else if (blocked(p.tag)) begin
				void'(push_pkt(p));
				emit(K_QUEUED, p.handle, p.tag, p.win);
			end else begin
				launch(p, K_SENT);
			end
		endfunction

		function void take_ack(int seq, int marker);
			int freed, sends;
			pkt_s h;
			freed = 0;
			sends = 0;
			if (marker != ACK_MARKER || seq == 0 || seq > NTAGS) begin
				emit(K_PASS, 0, 0, 0);
				return;
			end
			timers[seq - 1] = 0;
			if (open_cnt > 0) open_cnt--;
			for (int i = 0; i < flight_cnt; i++) begin
				if (flight[i].tag == seq) begin
					freed = flight[i].handle;
					for (int j = i; j < flight_cnt - 1; j++) flight[j] = flight[j + 1];
					flight_cnt--;
					break;
				end
			end
			outst &= ~(1 << (seq - 1));
			emit(K_ACK, freed, seq, 0);
			while (sends < MAX_RES - 1) begin
				if (q_cnt == lo_mark && wflag == 1) begin
					wflag = 0;
					toggled = 1;
				end
				if (q_cnt == 0) break;
				h = fifo[q_head];
				if (blocked(h.tag)) break;
				pop_pkt();
				launch(h, K_SENT_Q);
				sends++;
				if (open_cnt >= WIN) break;
			end
		endfunction

		function void age_timers();
			pkt_s o;
			for (int t = 0; t < NTAGS; t++) begin
				if (timers[t] == 0) continue;
				if (timers[t] > 1) begin
					timers[t]--;
					continue;
				end
				if (open_cnt == 0 || flight_cnt == 0) begin
					timers[t] = 0;
					continue;
				end
				// hold at 1 when out of result slots; it is handled again on the next tick
				if (nres >= MAX_RES) continue;
				o = flight[0];
				for (int j = 0; j < flight_cnt - 1; j++) flight[j] = flight[j + 1];
				flight[flight_cnt - 1] = o;
				emit(K_RESEND, o.handle, o.tag, o.win);
				timers[t] = reload();
			end
			if (nres == 0) emit(K_IDLE, 0, 0, 0);
		endfunction

		function void note_input(in_t x);
			out_t r;
			nres = 0;
			toggled = 0;
			case (x.operation)
				OP_SEND: outgoing(int'(x.packet_handle));
				OP_ACK:  take_ack(int'(x.ack_seq), int'(x.ack_marker));
				OP_TICK: age_timers();
				default: emit(K_IDLE, 0, 0, 0);
			endcase
			for (int k = 0; k < nres; k++) begin
				r.kind = kind_t'(res_kind[k]);
				r.out_handle = 16'(res_handle[k]);
				r.seq_tag = 6'(res_tag[k]);
				r.window_tag = 8'(res_win[k]);
				r.wait_on = 1'(wflag);
				r.wait_changed = 1'(toggled);
				r.last = (k == nres - 1);
				expected_results.push_back(r);
			end
		endfunction

		function void check_result(out_t a);
			out_t e;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, a);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			if (a.kind !== e.kind || a.out_handle !== e.out_handle
					|| a.seq_tag !== e.seq_tag || a.window_tag !== e.window_tag
					|| a.wait_on !== e.wait_on || a.wait_changed !== e.wait_changed
					|| a.last !== e.last) begin
				$display("%0t: mismatch expected %p actual %p", $time, e, a);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	swtx_scoreboard sb;
	int cycles;
	int burst_left;
	int stall_pct;

	sliding_window_tx_controller_top #(
		.WINDOW(WIN),
		.QUEUE_DEPTH(QDEPTH),
		.HANDLE_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	// receiver stall pattern: a redrawn stall rate of 35 or 70 percent, sometimes none at all
	always @(negedge clk) begin
		if (cycles % 64 == 0) stall_pct <= $urandom_range(0, 2) * 35;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic drive(in_t x);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		in_valid <= 1;
		in_data <= x;
		do @(posedge clk); while (in_stall);
		sb.note_input(x);
		burst_left--;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] d);
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	function automatic in_t make_item(op_t op, int handle, int seq, int marker);
		in_t x;
		x.operation = op;
		x.packet_handle = 16'(handle);
		x.ack_seq = 8'(seq);
		x.ack_marker = 8'(marker);
		return x;
	endfunction

	function automatic in_t rand_item();
		int r;
		in_t x;
		r = $urandom_range(0, 99);
		x.packet_handle = 16'($urandom);
		x.ack_seq = 8'($urandom_range(1, NTAGS));
		x.ack_marker = ACK_MARKER;
		if (r < 50) begin
			x.operation = OP_SEND;
		end else if (r < 80) begin
			x.operation = OP_ACK;
			if ($urandom_range(0, 99) < 15) begin
				x.ack_seq = 8'($urandom);
				x.ack_marker = 8'($urandom);
			end
		end else if (r < 95) begin
			x.operation = OP_TICK;
		end else begin
			x.operation = OP_NONE;
		end
		return x;
	endfunction

	task automatic random_items(int n);
		for (int i = 0; i < n; i++) drive(rand_item());
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		cycles = 0;
		burst_left = 0;
		stall_pct = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		cfg_wr_en = 0;
		cfg_index = CFG_HIGH_MARK;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: handle extremes, round inversion, queueing, bad and unknown acks
		drive(make_item(OP_SEND, 16'h0000, 0, 0));
		drive(make_item(OP_SEND, 16'hFFFF, 0, 0));
		drive(make_item(OP_SEND, 16'hA5A5, 0, 0));
		drive(make_item(OP_SEND, 16'h5A5A, 0, 0));
		drive(make_item(OP_SEND, 16'h1234, 0, 0));
		drive(make_item(OP_ACK, 0, 1, 8'hFE));
		drive(make_item(OP_ACK, 0, 0, 8'hFF));
		drive(make_item(OP_ACK, 0, 5, 8'hFF));
		drive(make_item(OP_ACK, 0, 8'hFF, 8'h00));
		drive(make_item(OP_ACK, 0, 1, 8'hFF));
		drive(make_item(OP_ACK, 0, 2, 8'hFF));
		drive(make_item(OP_ACK, 0, 2, 8'hFF));
		drive(make_item(OP_ACK, 0, 3, 8'hFF));
		drive(make_item(OP_ACK, 0, 4, 8'hFF));
		drive(make_item(OP_ACK, 0, 1, 8'hFF));
		drive(make_item(OP_TICK, 0, 0, 0));
		drive(make_item(OP_NONE, 16'hFFFF, 8'hFF, 8'hFF));
		settle();

		// tight marks and fast expiry
		write_reg(CFG_HIGH_MARK, 3);
		write_reg(CFG_LOW_MARK, 1);
		write_reg(CFG_TIMEOUT, 2);
		random_items(90);
		settle();

		write_reg(CFG_HIGH_MARK, 0);
		write_reg(CFG_LOW_MARK, 0);
		write_reg(CFG_TIMEOUT, 0);
		random_items(40);
		settle();

		// build a deep queue with no acks, then drain it
		write_reg(CFG_HIGH_MARK, 40);
		write_reg(CFG_LOW_MARK, 20);
		write_reg(CFG_TIMEOUT, 16'hFFFF);
		for (int i = 0; i < 60; i++) drive(make_item(OP_SEND, $urandom, 0, 0));
		for (int i = 0; i < 20; i++) drive(make_item(OP_ACK, 0, $urandom_range(1, NTAGS), 8'hFF));
		settle();

		write_reg(CFG_HIGH_MARK, 10);
		write_reg(CFG_LOW_MARK, 5);
		write_reg(CFG_TIMEOUT, 3);
		random_items(85);
		settle();

		if (sb.expected_results.size() == 0 && sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

@@ sim.f @@
design/swtx_pkg.sv
design/swtx_queue.sv
design/sliding_window_tx_controller_top.sv
verif/tb.sv
